@@ src/crsp_pkg.sv @@
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared widths, register indexes and state codes for the range-sum pair
// counter.
// ----------------------------------------------------------------------------
package crsp_pkg;

  localparam int SAMPLE_W = 32;   // width of one input number
  localparam int TOTAL_W  = 32;   // width of the emitted pair count
  localparam int PREFIX_W = 42;   // running prefix, two's complement
  localparam int DIFF_W   = 44;   // prefix difference plus sign headroom

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SUM_LOW  = 1'b0,
    REG_SUM_HIGH = 1'b1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

@@ src/crsp_stream_if.sv @@
// ----------------------------------------------------------------------------
// crsp_stream_if
// Valid/ready channels for the range-sum pair counter: one carries input
// numbers, the other carries the final pair counts.
// ----------------------------------------------------------------------------
interface crsp_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [crsp_pkg::SAMPLE_W-1:0] sample;
  logic                                is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface crsp_total_if;
  logic                         valid;
  logic                         ready;
  logic [crsp_pkg::TOTAL_W-1:0] pair_count;

  modport source (output valid, output pair_count, input ready);
  modport sink   (input valid, input pair_count, output ready);
endinterface

@@ src/count_range_sum_pairs_top.sv @@
// ----------------------------------------------------------------------------
// count_range_sum_pairs_top
// An accepted item is scanned against the N prefixes stored after its accept (N is
// the item's position in the sequence, at most MAX_ITEMS), one entry per cycle
// through the single read port of the prefix memory; a new item is taken only
// once the previous one has finished its scan and drain.
// Reset (rst, synchronous): clears the sequence, both bounds and the output.
// The prefix memory is not cleared; only entries already written are read.
// ----------------------------------------------------------------------------
module count_range_sum_pairs_top #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  crsp_item_if.sink                       items,
  crsp_total_if.source                    totals,
  input  logic                            wr_en,
  input  crsp_pkg::cfg_reg_t              wr_index,
  input  logic [crsp_pkg::SAMPLE_W-1:0]   wr_data
);
  import crsp_pkg::*;

  // The count must be able to hold MAX_ITEMS itself; the memory index only
  // needs to address MAX_ITEMS entries.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] sum_low;
  logic signed [SAMPLE_W-1:0] sum_high;

  // Sequence state.
  logic signed [PREFIX_W-1:0] running_prefix;
  logic [CNT_W-1:0]           stored_count;
  logic [TOTAL_W-1:0]         running_total;
  logic                       cur_last;

  // Scan pipeline: address issue, memory data, registered difference.
  logic [CNT_W-1:0]           rd_addr;
  logic                       q_valid;
  logic                       diff_valid;
  logic signed [PREFIX_W-1:0] mem_q;
  logic signed [DIFF_W-1:0]   diff;
  logic                       hit;

  // Output register.
  logic                       out_valid;
  logic [TOTAL_W-1:0]         out_count;

  // Sequencer.
  state_t state;
  state_t state_next;
  logic   in_ready;
  logic   accept;
  logic   rd_issue;
  logic   finish;
  logic   mem_we;

  // Prefix memory: one write port (the old prefix at accept time) and one
  // registered read port used by the scan.
  logic signed [PREFIX_W-1:0] prefix_mem [MAX_ITEMS];

  assign accept = items.valid && in_ready;
  assign mem_we = accept && (stored_count < CNT_W'(MAX_ITEMS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[stored_count[IDX_W-1:0]] <= running_prefix;
    end
    if (rd_issue) begin
      mem_q <= prefix_mem[rd_addr[IDX_W-1:0]];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state. The scan walks entries 0 .. stored_count-1, then the drain
  // waits for the last difference to reach the total. A final result is only
  // loaded once the output register is free or being emptied this cycle.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_issue   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (items.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
        if (rd_addr == stored_count - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!q_valid && !diff_valid && (!cur_last || !out_valid || totals.ready)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A stored prefix counts when the new prefix minus it lies in the window.
  // An empty window (low above high) simply never hits.
  assign hit = (diff >= DIFF_W'(sum_low)) && (diff <= DIFF_W'(sum_high));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low        <= '0;
      sum_high       <= '0;
      running_prefix <= '0;
      stored_count   <= '0;
      running_total  <= '0;
      cur_last       <= 1'b0;
      rd_addr        <= '0;
      q_valid        <= 1'b0;
      diff_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_SUM_LOW:  sum_low  <= wr_data;
          REG_SUM_HIGH: sum_high <= wr_data;
          default: ;
        endcase
      end

      // On a new transaction the old prefix goes to memory (unless it is
      // full) and the sample is folded into the running prefix.
      if (accept) begin
        cur_last       <= items.is_last;
        running_prefix <= running_prefix
                          + {{(PREFIX_W-SAMPLE_W){items.sample[SAMPLE_W-1]}}, items.sample};
        if (mem_we) begin
          stored_count <= stored_count + CNT_W'(1);
        end
        rd_addr <= '0;
      end

      if (rd_issue) begin
        rd_addr <= rd_addr + CNT_W'(1);
      end

      q_valid    <= rd_issue;
      diff_valid <= q_valid;
      if (diff_valid && hit) begin
        running_total <= running_total + TOTAL_W'(1);
      end

      // A new result may replace one that leaves in the same cycle.
      if (finish && cur_last) begin
        out_valid      <= 1'b1;
        running_prefix <= '0;
        stored_count   <= '0;
        running_total  <= '0;
      end else if (totals.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    diff <= DIFF_W'(running_prefix) - DIFF_W'(mem_q);
    if (finish && cur_last) begin
      out_count <= running_total;
    end
  end

  assign items.ready       = in_ready;
  assign totals.valid      = out_valid;
  assign totals.pair_count = out_count;

  // The store never holds more prefixes than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(MAX_ITEMS))
    else $error("prefix count exceeds memory depth");

  // A result appears only at the end of a drain.
  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DRAIN)
    else $error("result loaded outside the drain");

  // The scan pipeline is empty whenever a new transaction can be taken.
  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !q_valid && !diff_valid)
    else $error("scan pipeline busy while idle");

  // The scan never reads past the stored prefixes.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> rd_addr < stored_count)
    else $error("scan address beyond stored prefixes");

endmodule
